// ===== rtl/cmri_pkg.sv =====
// ----------------------------------------------------------------------------
// cmri_pkg
// Default window length, shared widths, command codes and the sequencer state
// type of the centered mean-removal velocity integrator.
// ----------------------------------------------------------------------------
`default_nettype none

package cmri_pkg;

    // Default window length in samples
    localparam int WINDOW_DEF = 125;

    // Fixed field and state widths
    localparam int SAMPLE_W = 16;
    localparam int FRAC_W   = 16;
    localparam int ACC_W    = 48;
    localparam int VEL_W    = ACC_W - FRAC_W;

    // Item command codes
    localparam logic CMD_PROCESS = 1'b0;
    localparam logic CMD_RESTART = 1'b1;

    // Sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_OLD,
        S_CENTER,
        S_DIV,
        S_DIFF,
        S_ACC,
        S_OUT
    } t_state;

endpackage

`default_nettype wire

// ===== rtl/cmri_ram.sv =====
// ----------------------------------------------------------------------------
// cmri_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module cmri_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 125
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// ===== rtl/centered_mean_removal_integrator_unit.sv =====
// ----------------------------------------------------------------------------
// centered_mean_removal_integrator_unit
// Velocity estimate from one accelerometer axis: centered moving-average
// removal followed by a saturating fixed-point integrator.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_ready) moves one item: a command bit and
//   a signed 16-bit sample. Command restart clears count, sum, indices and
//   the integrator and gives no result.
//   Output channel (o_out_valid / i_out_ready) moves one velocity item.
//   During start-up only odd sample counts give a result; once WINDOW
//   samples are seen, every sample gives one.
//   One item is worked on at a time. A start-up even count is done when it
//   is accepted and leaves the unit idle. A result passes through S_OLD
//   (steady state only), S_CENTER, S_DIV, S_DIFF, S_ACC and S_OUT; the
//   radix-4 restoring divider for sum/count runs in S_DIV.
//   The sample store is a one-port-read RAM; steady state reads the oldest
//   sample on accept, then the center sample in the cycle after.
//   The result sits in an output register; a new item is accepted while it
//   waits, and only the load of the next result stalls behind it.
//   Reset (i_rst_n low, synchronous) acts as a restart and empties the
//   output register; the sample store itself is not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module centered_mean_removal_integrator_unit #(
    parameter int WINDOW = cmri_pkg::WINDOW_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    output logic                               o_in_ready,
    input  wire logic                          i_command,
    input  wire logic signed [cmri_pkg::SAMPLE_W-1:0] i_sample,
    output logic                               o_out_valid,
    input  wire logic                          i_out_ready,
    output logic signed [cmri_pkg::VEL_W-1:0]  o_velocity
);

    localparam int SAMPLE_W = cmri_pkg::SAMPLE_W;
    localparam int FRAC_W   = cmri_pkg::FRAC_W;
    localparam int ACC_W    = cmri_pkg::ACC_W;
    localparam int VEL_W    = cmri_pkg::VEL_W;
    localparam int IDX_W    = $clog2(WINDOW);
    localparam int CNT_W    = $clog2(WINDOW + 1);
    localparam int SUM_W    = SAMPLE_W + CNT_W;
    localparam int DVD_W    = SUM_W + FRAC_W;
    localparam int DVD_P    = DVD_W + (DVD_W % 2);
    localparam int DIV_IT   = DVD_P / 2;
    localparam int ITC_W    = $clog2(DIV_IT);
    localparam int DIFF_W   = DVD_P + 2;
    localparam int ACC_S_W  = ACC_W + 1;

    localparam logic [IDX_W-1:0] LAST_IDX   = IDX_W'(WINDOW - 1);
    localparam logic [IDX_W-1:0] CENTER_RST = IDX_W'(((WINDOW - 1) / 2 + 1) % WINDOW);
    localparam logic [CNT_W-1:0] WIN_CNT    = CNT_W'(WINDOW);
    localparam logic [ITC_W-1:0] IT_LAST    = ITC_W'(DIV_IT - 1);

    localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

    // Control and state registers
    cmri_pkg::t_state r_state, n_state;
    logic                       r_out_valid, n_out_valid;
    logic [CNT_W-1:0]           r_seen, n_seen;
    logic [IDX_W-1:0]           r_wi, n_wi;
    logic [IDX_W-1:0]           r_ci, n_ci;
    logic signed [SUM_W-1:0]    r_sum, n_sum;
    logic signed [ACC_W-1:0]    r_acc, n_acc;
    logic [ITC_W-1:0]           r_itc, n_itc;

    // Payload registers
    logic signed [SAMPLE_W-1:0] r_smp, n_smp;
    logic                       r_fwd, n_fwd;
    logic signed [SAMPLE_W-1:0] r_ctr, n_ctr;
    logic                       r_neg, n_neg;
    logic [CNT_W:0]             r_rem, n_rem;
    logic [DVD_P-1:0]           r_quo, n_quo;
    logic signed [DIFF_W-1:0]   r_diff, n_diff;
    logic signed [VEL_W-1:0]    r_vel, n_vel;

    // Sample store ports
    logic                       ram_we;
    logic [IDX_W-1:0]           ram_waddr;
    logic [SAMPLE_W-1:0]        ram_wdata;
    logic [IDX_W-1:0]           ram_raddr;
    logic [SAMPLE_W-1:0]        ram_rdata;

    logic                       in_acc;
    logic                       startup;
    logic                       out_free;
    logic [CNT_W:0]             seen_inc;
    logic [IDX_W-1:0]           st_raddr;

    cmri_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (WINDOW)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign o_in_ready  = (r_state == cmri_pkg::S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_velocity  = r_vel;

    assign in_acc   = i_in_valid && o_in_ready;
    assign startup  = (r_seen < WIN_CNT);
    assign out_free = !r_out_valid || i_out_ready;
    assign seen_inc = {1'b0, r_seen} + {{CNT_W{1'b0}}, 1'b1};
    assign st_raddr = IDX_W'(seen_inc >> 1);

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            cmri_pkg::S_IDLE: begin
                if (in_acc && i_command == cmri_pkg::CMD_PROCESS) begin
                    if (!startup) begin
                        n_state = cmri_pkg::S_OLD;
                    end else if (seen_inc[0]) begin
                        n_state = cmri_pkg::S_CENTER;
                    end
                end
            end
            cmri_pkg::S_OLD:    n_state = cmri_pkg::S_CENTER;
            cmri_pkg::S_CENTER: n_state = cmri_pkg::S_DIV;
            cmri_pkg::S_DIV: begin
                if (r_itc == IT_LAST) begin
                    n_state = cmri_pkg::S_DIFF;
                end
            end
            cmri_pkg::S_DIFF:   n_state = cmri_pkg::S_ACC;
            cmri_pkg::S_ACC:    n_state = cmri_pkg::S_OUT;
            cmri_pkg::S_OUT: begin
                if (out_free) begin
                    n_state = cmri_pkg::S_IDLE;
                end
            end
            default:            n_state = cmri_pkg::S_IDLE;
        endcase
    end

    // Datapath and store control
    always_comb begin
        logic [CNT_W:0]            t_rem;
        logic [DVD_P-1:0]          t_quo;
        logic [SUM_W-1:0]          mag;
        logic signed [DIFF_W-1:0]  ctr_ext;
        logic signed [ACC_S_W-1:0] acc_sum;
        logic signed [ACC_W-1:0]   vel_t;

        n_out_valid = r_out_valid && !i_out_ready;
        n_seen      = r_seen;
        n_wi        = r_wi;
        n_ci        = r_ci;
        n_sum       = r_sum;
        n_acc       = r_acc;
        n_itc       = r_itc;
        n_smp       = r_smp;
        n_fwd       = r_fwd;
        n_ctr       = r_ctr;
        n_neg       = r_neg;
        n_rem       = r_rem;
        n_quo       = r_quo;
        n_diff      = r_diff;
        n_vel       = r_vel;
        ram_we      = 1'b0;
        ram_waddr   = r_wi;
        ram_wdata   = i_sample;
        ram_raddr   = r_wi;
        t_rem       = r_rem;
        t_quo       = r_quo;
        mag         = '0;
        ctr_ext     = '0;
        acc_sum     = '0;
        vel_t       = '0;

        case (r_state)
            cmri_pkg::S_IDLE: begin
                if (in_acc) begin
                    n_smp = i_sample;
                    if (i_command == cmri_pkg::CMD_RESTART) begin
                        // Clear the estimator, keep the store
                        n_seen = '0;
                        n_wi   = '0;
                        n_ci   = CENTER_RST;
                        n_sum  = '0;
                        n_acc  = '0;
                    end else if (startup) begin
                        // Store, sum and fetch the middle sample so far
                        ram_we    = 1'b1;
                        ram_raddr = st_raddr;
                        n_fwd     = (st_raddr == r_wi);
                        n_sum     = r_sum + SUM_W'(i_sample);
                        n_seen    = CNT_W'(seen_inc);
                        n_wi      = (r_wi == LAST_IDX) ? '0 : r_wi + 1'b1;
                        n_ci      = (r_ci == LAST_IDX) ? '0 : r_ci + 1'b1;
                    end else begin
                        // Fetch the oldest sample first
                        ram_raddr = r_wi;
                        n_fwd     = 1'b0;
                    end
                end
            end
            cmri_pkg::S_OLD: begin
                // Swap oldest for newest, fetch the center sample
                ram_we    = 1'b1;
                ram_wdata = r_smp;
                ram_raddr = r_ci;
                n_sum     = r_sum - SUM_W'($signed(ram_rdata)) + SUM_W'(r_smp);
                n_wi      = (r_wi == LAST_IDX) ? '0 : r_wi + 1'b1;
                n_ci      = (r_ci == LAST_IDX) ? '0 : r_ci + 1'b1;
            end
            cmri_pkg::S_CENTER: begin
                // Capture center, load divider with |sum| * 2^16
                n_ctr = r_fwd ? r_smp : $signed(ram_rdata);
                n_neg = r_sum[SUM_W-1];
                mag   = r_sum[SUM_W-1] ? SUM_W'(-r_sum) : SUM_W'(r_sum);
                n_quo = DVD_P'({mag, {FRAC_W{1'b0}}});
                n_rem = '0;
                n_itc = '0;
            end
            cmri_pkg::S_DIV: begin
                // Two restoring steps a cycle
                for (int k = 0; k < 2; k++) begin
                    t_rem = {t_rem[CNT_W-1:0], t_quo[DVD_P-1]};
                    t_quo = {t_quo[DVD_P-2:0], 1'b0};
                    if (t_rem >= {1'b0, r_seen}) begin
                        t_rem    = t_rem - {1'b0, r_seen};
                        t_quo[0] = 1'b1;
                    end
                end
                n_rem = t_rem;
                n_quo = t_quo;
                n_itc = r_itc + 1'b1;
            end
            cmri_pkg::S_DIFF: begin
                // Center minus signed mean
                ctr_ext = DIFF_W'(r_ctr) <<< FRAC_W;
                if (r_neg) begin
                    n_diff = ctr_ext + $signed(DIFF_W'(r_quo));
                end else begin
                    n_diff = ctr_ext - $signed(DIFF_W'(r_quo));
                end
            end
            cmri_pkg::S_ACC: begin
                // Saturating integrate
                acc_sum = ACC_S_W'(r_acc) + ACC_S_W'(r_diff);
                if (acc_sum[ACC_S_W-1] != acc_sum[ACC_S_W-2]) begin
                    n_acc = acc_sum[ACC_S_W-1] ? ACC_MIN : ACC_MAX;
                end else begin
                    n_acc = acc_sum[ACC_W-1:0];
                end
            end
            cmri_pkg::S_OUT: begin
                // Truncate toward zero; the integer part always fits
                if (out_free) begin
                    vel_t = r_acc + (r_acc[ACC_W-1] ?
                            ACC_W'({FRAC_W{1'b1}}) : ACC_W'(0));
                    n_vel       = vel_t[ACC_W-1:FRAC_W];
                    n_out_valid = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    // Registers with reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= cmri_pkg::S_IDLE;
            r_out_valid <= 1'b0;
            r_seen      <= '0;
            r_wi        <= '0;
            r_ci        <= CENTER_RST;
            r_sum       <= '0;
            r_acc       <= '0;
            r_itc       <= '0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_seen      <= n_seen;
            r_wi        <= n_wi;
            r_ci        <= n_ci;
            r_sum       <= n_sum;
            r_acc       <= n_acc;
            r_itc       <= n_itc;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_smp  <= n_smp;
        r_fwd  <= n_fwd;
        r_ctr  <= n_ctr;
        r_neg  <= n_neg;
        r_rem  <= n_rem;
        r_quo  <= n_quo;
        r_diff <= n_diff;
        r_vel  <= n_vel;
    end

`ifndef SYNTHESIS
    // Count never runs past the window
    a_seen_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_seen <= WIN_CNT)
        else $error("sample count beyond window");

    // Center read never targets the slot being replaced
    a_center_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == cmri_pkg::S_OLD |-> ram_raddr != r_wi)
        else $error("center read collides with write slot");

    // Even start-up count finishes at once with no result
    a_even_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && i_command == cmri_pkg::CMD_PROCESS && startup && !seen_inc[0]
        |=> r_state == cmri_pkg::S_IDLE)
        else $error("even start-up item left idle");
`endif

endmodule

`default_nettype wire

// ===== tb/centered_mean_removal_integrator_unit_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// centered_mean_removal_integrator_unit_tb
// Self-checking bench for the velocity integrator. A scoreboard keeps its own
// copy of the sample window, running sum and integrator, predicts every
// velocity item from the accepted input items and checks each output item
// in order. Directed extremes and restarts come first, then random sample
// streams under several idle and stall patterns, including a long output
// hold-off that backs up the input.
// ----------------------------------------------------------------------------

class velocity_scoreboard;

    localparam int     WIN      = cmri_pkg::WINDOW_DEF;
    localparam longint FRAC_ONE = longint'(1) << cmri_pkg::FRAC_W;
    localparam longint INTEG_MAX = (longint'(1) << (cmri_pkg::ACC_W - 1)) - 1;
    localparam longint INTEG_MIN = -INTEG_MAX - 1;
    localparam longint VEL_MAX  = (longint'(1) << (cmri_pkg::VEL_W - 1)) - 1;
    localparam longint VEL_MIN  = -VEL_MAX - 1;

    logic signed [cmri_pkg::SAMPLE_W-1:0] window_mem [WIN];
    longint      win_sum;
    longint      integ;
    int unsigned n_seen;
    int unsigned wr_ptr;
    int unsigned mid_ptr;

    logic signed [cmri_pkg::VEL_W-1:0] pending_vel [$];

    int errors;
    int n_items;
    int n_restarts;
    int n_warmup;
    int n_steady;

    function new();
        foreach (window_mem[i]) window_mem[i] = '0;
        restart_state();
        errors     = 0;
        n_items    = 0;
        n_restarts = 0;
        n_warmup   = 0;
        n_steady   = 0;
    endfunction

    // Clear count, sum, pointers and integrator; the window contents stay
    function void restart_state();
        win_sum = 0;
        integ   = 0;
        n_seen  = 0;
        wr_ptr  = 0;
        mid_ptr = ((WIN - 1) / 2 + 1) % WIN;
    endfunction

    // Add centre minus mean to the integrator, return the new velocity
    function logic signed [cmri_pkg::VEL_W-1:0] integrate(longint centre, longint divisor);
        longint mean;
        longint vel;
        mean  = (win_sum * FRAC_ONE) / divisor;
        integ = integ + centre * FRAC_ONE - mean;
        if (integ > INTEG_MAX) integ = INTEG_MAX;
        if (integ < INTEG_MIN) integ = INTEG_MIN;
        vel = integ / FRAC_ONE;
        if (vel > VEL_MAX) vel = VEL_MAX;
        if (vel < VEL_MIN) vel = VEL_MIN;
        return vel[cmri_pkg::VEL_W-1:0];
    endfunction

    // Advance the model by one accepted input item
    function void note_item(logic cmd, logic signed [cmri_pkg::SAMPLE_W-1:0] s);
        n_items++;
        if (cmd == cmri_pkg::CMD_RESTART) begin
            restart_state();
            n_restarts++;
            return;
        end
        if (n_seen < WIN) begin
            // start-up: window is everything seen so far, odd counts only
            win_sum += s;
            window_mem[wr_ptr] = s;
            n_seen++;
            if (n_seen % 2 == 1) begin
                pending_vel.push_back(integrate(window_mem[n_seen / 2], n_seen));
                n_warmup++;
            end
        end else begin
            // steady: drop the oldest sample, centre is half a window back
            win_sum = win_sum - window_mem[wr_ptr] + s;
            window_mem[wr_ptr] = s;
            pending_vel.push_back(integrate(window_mem[mid_ptr], WIN));
            n_steady++;
        end
        wr_ptr  = (wr_ptr + 1 == WIN) ? 0 : wr_ptr + 1;
        mid_ptr = (mid_ptr + 1 == WIN) ? 0 : mid_ptr + 1;
    endfunction

    // Compare one output item with the oldest prediction
    function void check_velocity(logic signed [cmri_pkg::VEL_W-1:0] got);
        logic signed [cmri_pkg::VEL_W-1:0] want;
        if (pending_vel.size() == 0) begin
            $display("%0t: velocity item with nothing pending, expected none, actual %0d",
                     $time, got);
            errors++;
            return;
        end
        want = pending_vel.pop_front();
        if (want !== got) begin
            $display("%0t: velocity mismatch, expected %0d, actual %0d", $time, want, got);
            errors++;
        end
    endfunction

endclass

module centered_mean_removal_integrator_unit_tb;

    localparam int WIN             = cmri_pkg::WINDOW_DEF;
    localparam int SAMPLE_W        = cmri_pkg::SAMPLE_W;
    localparam int VEL_W           = cmri_pkg::VEL_W;
    localparam int QUIET_LIMIT     = 3000;
    localparam int HOLD_CYCLES     = 500;
    localparam int ITEMS_PER_PHASE = 185;
    localparam int SETTLE_CYCLES   = 40;

    logic                       i_clk;
    logic                       i_rst_n;
    logic                       in_valid;
    logic                       in_ready;
    logic                       command;
    logic signed [SAMPLE_W-1:0] sample;
    logic                       out_valid;
    logic                       out_ready;
    logic signed [VEL_W-1:0]    velocity;

    int idle_pct;
    int stall_pct;
    bit rx_hold;
    int quiet_cycles;

    velocity_scoreboard sb;

    centered_mean_removal_integrator_unit #(
        .WINDOW(WIN)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (in_valid),
        .o_in_ready (in_ready),
        .i_command  (command),
        .i_sample   (sample),
        .o_out_valid(out_valid),
        .i_out_ready(out_ready),
        .o_velocity (velocity)
    );

    // Free-running clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Drive receiver ready, low throughout a hold-off
    always @(negedge i_clk) begin
        out_ready <= !rx_hold && ($urandom_range(0, 99) >= stall_pct);
    end

    // Check every accepted velocity item
    always @(posedge i_clk) begin
        if (i_rst_n && out_valid && out_ready)
            sb.check_velocity(velocity);
    end

    // Stop the run when nothing moves for too long
    always @(posedge i_clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("%0t: no item moved for %0d cycles", $time, QUIET_LIMIT);
                $display("centered_mean_removal_integrator_unit_tb NOT OK");
                $finish;
            end
        end
    end

    // Offer one item, hold it until accepted, return at the next falling edge
    task automatic send_item(input logic cmd, input logic signed [SAMPLE_W-1:0] s);
        if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge i_clk);
        end
        in_valid <= 1'b1;
        command  <= cmd;
        sample   <= s;
        do @(posedge i_clk); while (!in_ready);
        sb.note_item(cmd, s);
        @(negedge i_clk);
    endtask

    // Stop sending and wait until every predicted item has come out
    task automatic drain();
        in_valid <= 1'b0;
        while (sb.pending_vel.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    initial begin
        logic                       cmd;
        logic signed [SAMPLE_W-1:0] s;

        sb           = new();
        i_rst_n      = 1'b0;
        in_valid     = 1'b0;
        command      = cmri_pkg::CMD_PROCESS;
        sample       = '0;
        out_ready    = 1'b0;
        rx_hold      = 1'b0;
        idle_pct     = 0;
        stall_pct    = 0;
        quiet_cycles = 0;

        // Hold reset, then release it
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed: restarts, extremes, odd and even start-up counts
        send_item(cmri_pkg::CMD_RESTART, 16'sh8000);
        send_item(cmri_pkg::CMD_PROCESS, 16'sh7FFF);
        send_item(cmri_pkg::CMD_PROCESS, 16'sh8000);
        send_item(cmri_pkg::CMD_PROCESS, 16'sh7FFF);
        send_item(cmri_pkg::CMD_PROCESS, 16'sh8000);
        send_item(cmri_pkg::CMD_PROCESS, 16'sh7FFF);
        send_item(cmri_pkg::CMD_PROCESS, 16'sh0000);
        send_item(cmri_pkg::CMD_PROCESS, -16'sd1);
        send_item(cmri_pkg::CMD_PROCESS, 16'sd1);
        send_item(cmri_pkg::CMD_PROCESS, 16'sh5555);
        send_item(cmri_pkg::CMD_PROCESS, 16'shAAAA);
        send_item(cmri_pkg::CMD_RESTART, 16'sh7FFF);
        send_item(cmri_pkg::CMD_PROCESS, 16'sh8000);
        send_item(cmri_pkg::CMD_PROCESS, 16'sh8000);
        send_item(cmri_pkg::CMD_PROCESS, 16'sh8000);
        send_item(cmri_pkg::CMD_RESTART, 16'sh0000);
        send_item(cmri_pkg::CMD_RESTART, 16'shFFFF);
        send_item(cmri_pkg::CMD_PROCESS, 16'sh7FFF);
        send_item(cmri_pkg::CMD_PROCESS, 16'sh7FFF);
        send_item(cmri_pkg::CMD_PROCESS, 16'sh8000);
        drain();

        // Random streams under four idle and stall patterns
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 64; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 64; end
                default: begin idle_pct = 15; stall_pct = 15; end
            endcase
            // Block the output for a long stretch so the input backs up
            if (phase == 0) begin
                fork
                    begin
                        rx_hold = 1'b1;
                        repeat (HOLD_CYCLES) @(posedge i_clk);
                        rx_hold = 1'b0;
                    end
                join_none
            end
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                cmd = ($urandom_range(0, 199) == 0) ? cmri_pkg::CMD_RESTART
                                                    : cmri_pkg::CMD_PROCESS;
                case ($urandom_range(0, 7))
                    0: s = 16'sh7FFF;
                    1: s = 16'sh8000;
                    2: s = SAMPLE_W'($urandom_range(0, 63)) - 16'sd32;
                    default: s = SAMPLE_W'($urandom());
                endcase
                send_item(cmd, s);
            end
            // Pause the sender until every result is out
            drain();
        end

        $display("Run covered %0d input items with %0d restarts;", sb.n_items, sb.n_restarts);
        $display("checked %0d start-up and %0d full-window velocity items, %0d errors.",
                 sb.n_warmup, sb.n_steady, sb.errors);
        if (sb.errors == 0) begin
            $display("centered_mean_removal_integrator_unit_tb OK");
        end else begin
            $display("centered_mean_removal_integrator_unit_tb NOT OK");
        end
        $finish;
    end

endmodule

// ===== files.f =====
rtl/cmri_pkg.sv
rtl/cmri_ram.sv
rtl/centered_mean_removal_integrator_unit.sv
tb/centered_mean_removal_integrator_unit_tb.sv
